FILE: design/fcbm_pkg.sv
package fcbm_pkg;

	// Bus command codes carried in each request.
	typedef enum logic [1:0] {
		CMD_WRITE  = 2'd0,
		CMD_READ   = 2'd1,
		CMD_FREEZE = 2'd2,
		CMD_RESET  = 2'd3
	} cmd_t;

	// Where the host takes read data from.
	typedef enum logic [1:0] {
		SRC_FIXED = 2'd0,
		SRC_CTRL  = 2'd1,
		SRC_RAM   = 2'd2,
		SRC_ROM   = 2'd3
	} src_t;

	// Register byte addresses on the configuration port.
	localparam int unsigned AddrWidth = 3;
	localparam logic [AddrWidth-1:0] ADDR_CART_HAS_RAM = 3'd0;

	// Address decode constants.
	localparam logic [7:0] PAGE_IO1    = 8'hDE;
	localparam logic [7:0] PAGE_IO2    = 8'hDF;
	localparam logic [7:0] LOW_CTRL0   = 8'h00;
	localparam logic [7:0] LOW_CTRL1   = 8'h01;
	localparam logic [4:0] OFFSET_HIGH = 5'h1F;
	localparam logic [7:0] UNMAPPED    = 8'hFF;
	localparam logic [7:0] ULTIMAX_MASK = 8'h83;

	// One input request.
	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] address;
		logic [7:0]  write_data;
	} in_t;

	// One result.
	typedef struct packed {
		logic [7:0]  read_data;
		logic [1:0]  read_source;
		logic [12:0] mem_offset;
		logic        mem_bank;
		logic        ram_write;
		logic        bank_reload;
		logic        exrom_line;
		logic        game_line;
		logic        low_rom_is_ram;
		logic        nmi_request;
		logic        warm_reset_request;
	} out_t;

	// Mode flags decoded from the control registers.
	typedef struct packed {
		logic map16k;
		logic ultimax;
		logic release_strobe;
		logic disable_cart;
		logic bank;
	} mode_t;

	// Levels driven on the host lines.
	typedef struct packed {
		logic exrom;
		logic game;
		logic overlay;
	} lines_t;

	// Control 0 decode; release fires on a rising edge of bit 1.
	function automatic mode_t decode_ctrl0(input logic [7:0] old_val, input logic [7:0] new_val);
		mode_t f;
		f.bank           = new_val[2];
		f.disable_cart   = new_val[3];
		f.release_strobe = !old_val[1] && new_val[1];
		f.ultimax        = ((new_val & ULTIMAX_MASK) == 8'h00);
		f.map16k         = !f.ultimax && !new_val[0];
		return f;
	endfunction

	// Control 1 step relation: one down maps RAM in, one up maps ROM back.
	function automatic mode_t ctrl1_relation(input mode_t f_in, input logic [7:0] old_val,
			input logic [7:0] new_val, input logic ctrl0_bit0);
		mode_t f;
		f = f_in;
		if (old_val - 8'd1 == new_val) begin
			f.map16k  = 1'b0;
			f.ultimax = 1'b1;
		end else if (old_val + 8'd1 == new_val) begin
			f.ultimax = 1'b0;
			f.map16k  = !ctrl0_bit0;
		end
		return f;
	endfunction

endpackage

FILE: design/fcbm_apb.sv
module fcbm_apb (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [fcbm_pkg::AddrWidth-1:0]    paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	output logic                              cart_has_ram
);

	logic cart_has_ram_q;
	logic wr_en;
	logic reg_hit;

	// Only the register at byte address zero exists.
	assign reg_hit = (paddr[fcbm_pkg::AddrWidth-1:2] ==
		fcbm_pkg::ADDR_CART_HAS_RAM[fcbm_pkg::AddrWidth-1:2]);
	assign wr_en   = psel && penable && pwrite && reg_hit;
	assign pready  = 1'b1;

	// The RAM-present bit comes out of reset set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cart_has_ram_q <= 1'b1;
		end else if (wr_en) begin
			cart_has_ram_q <= pwdata[0];
		end
	end

	// Read back the register, zero elsewhere.
	always_comb begin
		prdata = 32'd0;
		if (reg_hit) begin
			prdata = {31'd0, cart_has_ram_q};
		end
	end

	assign cart_has_ram = cart_has_ram_q;

endmodule

FILE: design/fcbm_core.sv
module fcbm_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  logic            cart_has_ram,
	input  fcbm_pkg::in_t   item,
	output fcbm_pkg::out_t  result
);

	logic [7:0]      ctrl_zero_q, ctrl_one_q, ctrl_zero_last_q, ctrl_one_last_q;
	fcbm_pkg::mode_t mode_q;
	logic [31:0]     saved_q;
	logic            frozen_q;
	logic            loaded_valid_q;
	logic            loaded_bank_q;
	fcbm_pkg::lines_t lines_q;

	logic [7:0]      ctrl_zero_d, ctrl_one_d, ctrl_zero_last_d, ctrl_one_last_d;
	fcbm_pkg::mode_t mode_d;
	logic [31:0]     saved_d;
	logic            frozen_d;
	logic            loaded_valid_d;
	logic            loaded_bank_d;
	fcbm_pkg::lines_t lines_d;

	logic [7:0]      page;
	logic [7:0]      low;
	logic [12:0]     offset;
	logic            do_apply;
	fcbm_pkg::mode_t f;

	assign page   = item.address[15:8];
	assign low    = item.address[7:0];
	assign offset = {fcbm_pkg::OFFSET_HIGH, low};

	// Decode one request against the current state.
	always_comb begin
		ctrl_zero_d      = ctrl_zero_q;
		ctrl_one_d       = ctrl_one_q;
		ctrl_zero_last_d = ctrl_zero_last_q;
		ctrl_one_last_d  = ctrl_one_last_q;
		mode_d           = mode_q;
		saved_d          = saved_q;
		frozen_d         = frozen_q;
		loaded_valid_d   = loaded_valid_q;
		loaded_bank_d    = loaded_bank_q;
		lines_d          = lines_q;
		do_apply         = 1'b0;
		f                = mode_q;

		result                    = '0;
		result.read_data          = fcbm_pkg::UNMAPPED;
		result.read_source        = fcbm_pkg::SRC_FIXED;

		case (fcbm_pkg::cmd_t'(item.command))
			fcbm_pkg::CMD_WRITE: begin
				if (page == fcbm_pkg::PAGE_IO1) begin
					if (cart_has_ram) begin
						result.ram_write  = 1'b1;
						result.mem_offset = offset;
					end
				end else if (page == fcbm_pkg::PAGE_IO2) begin
					if (low == fcbm_pkg::LOW_CTRL0) begin
						ctrl_zero_d      = item.write_data;
						f                = fcbm_pkg::decode_ctrl0(ctrl_zero_last_q, item.write_data);
						ctrl_zero_last_d = item.write_data;
						do_apply         = 1'b1;
					end else if (low == fcbm_pkg::LOW_CTRL1) begin
						ctrl_one_d      = item.write_data;
						f               = fcbm_pkg::ctrl1_relation(mode_q, ctrl_one_last_q,
							item.write_data, ctrl_zero_q[0]);
						ctrl_one_last_d = item.write_data;
						do_apply        = 1'b1;
					end
				end
			end
			fcbm_pkg::CMD_READ: begin
				if (page == fcbm_pkg::PAGE_IO1) begin
					if (cart_has_ram) begin
						result.read_source = fcbm_pkg::SRC_RAM;
						result.mem_offset  = offset;
					end
				end else if (page == fcbm_pkg::PAGE_IO2 && low == fcbm_pkg::LOW_CTRL1) begin
					result.read_source = fcbm_pkg::SRC_CTRL;
					result.read_data   = ctrl_one_q;
				end else if (page == fcbm_pkg::PAGE_IO2 && low != fcbm_pkg::LOW_CTRL0) begin
					result.read_source = fcbm_pkg::SRC_ROM;
					result.mem_offset  = offset;
					result.mem_bank    = loaded_valid_q ? loaded_bank_q : mode_q.bank;
				end
			end
			fcbm_pkg::CMD_FREEZE: begin
				// The snapshot is only taken on the first press.
				if (!frozen_q) begin
					saved_d = {ctrl_one_last_q, ctrl_zero_last_q, ctrl_one_q, ctrl_zero_q};
				end
				frozen_d            = 1'b1;
				loaded_valid_d      = 1'b1;
				loaded_bank_d       = 1'b0;
				result.bank_reload  = 1'b1;
				lines_d             = '{exrom: 1'b1, game: 1'b0, overlay: 1'b1};
				result.nmi_request  = 1'b1;
			end
			default: begin
				frozen_d                  = 1'b0;
				do_apply                  = 1'b1;
				result.warm_reset_request = 1'b1;
			end
		endcase

		// Apply the new mode: release restore, then bank and host lines.
		if (do_apply) begin
			if (f.release_strobe) begin
				frozen_d         = 1'b0;
				ctrl_zero_d      = saved_q[7:0];
				ctrl_one_d       = saved_q[15:8];
				f                = fcbm_pkg::decode_ctrl0(saved_q[23:16], saved_q[7:0]);
				ctrl_zero_last_d = saved_q[7:0];
				f                = fcbm_pkg::ctrl1_relation(f, saved_q[31:24], saved_q[15:8],
					saved_q[0]);
				ctrl_one_last_d  = saved_q[31:24];
			end
			f.release_strobe = 1'b0;
			mode_d           = f;
			if (f.disable_cart) begin
				lines_d = '{exrom: 1'b1, game: 1'b1, overlay: 1'b0};
			end else begin
				if (!(loaded_valid_q && loaded_bank_q == f.bank)) begin
					loaded_valid_d     = 1'b1;
					loaded_bank_d      = f.bank;
					result.bank_reload = 1'b1;
					result.mem_bank    = f.bank;
				end
				if (frozen_d) begin
					lines_d = '{exrom: 1'b1, game: 1'b0, overlay: 1'b1};
				end else if (f.ultimax) begin
					lines_d = '{exrom: 1'b1, game: 1'b0, overlay: 1'b1};
				end else if (f.map16k) begin
					lines_d = '{exrom: 1'b0, game: 1'b0, overlay: 1'b0};
				end else begin
					lines_d = '{exrom: 1'b0, game: 1'b1, overlay: 1'b0};
				end
			end
		end

		result.exrom_line     = lines_d.exrom;
		result.game_line      = lines_d.game;
		result.low_rom_is_ram = lines_d.overlay;
	end

	// Mapper state advances when a request moves to the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_zero_q      <= '0;
			ctrl_one_q       <= '0;
			ctrl_zero_last_q <= '0;
			ctrl_one_last_q  <= '0;
			mode_q           <= '0;
			saved_q          <= '0;
			frozen_q         <= 1'b0;
			loaded_valid_q   <= 1'b0;
			loaded_bank_q    <= 1'b0;
			lines_q          <= '{exrom: 1'b0, game: 1'b1, overlay: 1'b0};
		end else if (fire) begin
			ctrl_zero_q      <= ctrl_zero_d;
			ctrl_one_q       <= ctrl_one_d;
			ctrl_zero_last_q <= ctrl_zero_last_d;
			ctrl_one_last_q  <= ctrl_one_last_d;
			mode_q           <= mode_d;
			saved_q          <= saved_d;
			frozen_q         <= frozen_d;
			loaded_valid_q   <= loaded_valid_d;
			loaded_bank_q    <= loaded_bank_d;
			lines_q          <= lines_d;
		end
	end

endmodule

FILE: design/freezer_cartridge_bank_mapper.sv
// Freeze cartridge bank mapper.
// The input channel (in_valid, in_stall, in_data) takes one request per cycle
// while in_stall is low: a bus write, a bus read, a freeze press or a reset
// press. Every request gives exactly one result on the output channel
// (out_valid, out_stall, out_data): read routing, RAM/ROM offset, bank reloads,
// the exrom/game/overlay levels and the NMI and warm-reset pulses.
// A request is captured in the input register, decoded against the mapper
// state and shown from the result register. Throughput is one request per
// cycle while the receiver does not stall; the mapper state updates as each
// request moves into the result register. When the receiver stalls, the
// result holds in the result register and one more request waits in the input
// register; only then is in_stall raised. Reset empties both registers, clears
// all control registers and the freeze snapshot, leaves no bank loaded and
// drives 8K mode (exrom low, game high, overlay off). The APB port holds one
// register, cart_has_ram at byte address 0, which resets to 1; the user must
// ensure it is written only while no request is in flight; no check is built in.
module freezer_cartridge_bank_mapper (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  fcbm_pkg::in_t                   in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output fcbm_pkg::out_t                  out_data,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [fcbm_pkg::AddrWidth-1:0]  paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	logic           valid_s1;
	fcbm_pkg::in_t  item_s1;
	logic           valid_s2;
	fcbm_pkg::out_t result_s2;
	fcbm_pkg::out_t result;
	logic           advance;
	logic           cart_has_ram;

	fcbm_apb u_apb (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.cart_has_ram (cart_has_ram)
	);

	fcbm_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (advance),
		.cart_has_ram (cart_has_ram),
		.item         (item_s1),
		.result       (result)
	);

	// A request moves on when the result register is free or being emptied.
	assign advance  = valid_s1 && !(valid_s2 && out_stall);
	assign in_stall = valid_s1 && valid_s2 && out_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || !out_stall) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = result_s2;

endmodule

FILE: design/fcbm_checker.sv
module fcbm_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_stall,
	input logic                            out_valid,
	input logic                            out_stall,
	input fcbm_pkg::out_t                  out_data
);

	// A stalled result stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A freeze result always drives the frozen line levels.
	a_freeze_lines: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.nmi_request |->
		out_data.exrom_line && !out_data.game_line && out_data.low_rom_is_ram)
		else $error("freeze result without frozen lines");

	// RAM writes target the top page of RAM and carry no read routing.
	a_ram_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.ram_write |->
		out_data.read_source == fcbm_pkg::SRC_FIXED &&
		out_data.mem_offset[12:8] == fcbm_pkg::OFFSET_HIGH &&
		!out_data.bank_reload && !out_data.nmi_request)
		else $error("bad RAM write result");

	// A warm reset pulse never comes with a freeze pulse or a memory access.
	a_warm_reset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.warm_reset_request |->
		!out_data.nmi_request && !out_data.ram_write &&
		out_data.read_source == fcbm_pkg::SRC_FIXED)
		else $error("warm reset result mixed with other requests");

	// Input stall only rises while the output side is stalled.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

endmodule

bind freezer_cartridge_bank_mapper fcbm_checker u_fcbm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
